FILE: hdl/lfms_pkg.sv
// ----------------------------------------------------------------------------
// lfms_pkg
// Shared types and codes for the frustum cull and mesh LOD selector.
// ----------------------------------------------------------------------------
package lfms_pkg;

	typedef enum logic [2:0] {
		DEC_BYPASS     = 3'd0,
		DEC_NO_MESH    = 3'd1,
		DEC_NEAR       = 3'd2,
		DEC_TOO_FAR    = 3'd3,
		DEC_OFF_SCREEN = 3'd4,
		DEC_SIMPLE     = 3'd5,
		DEC_FULL       = 3'd6
	} dec_t;

	localparam logic [7:0] REG_CAMERA_POS  = 8'd0;
	localparam logic [7:0] REG_CLIP_ROW_X  = 8'd1;
	localparam logic [7:0] REG_CLIP_ROW_Y  = 8'd2;
	localparam logic [7:0] REG_CLIP_ROW_W  = 8'd3;
	localparam logic [7:0] REG_FOV_BIAS    = 8'd4;
	localparam logic [7:0] REG_LOD_QUALITY = 8'd5;
	localparam logic [7:0] REG_BYPASS_MIN  = 8'd6;
	localparam logic [7:0] REG_SKY_SHADER  = 8'd7;

	localparam logic [15:0] QUALITY_ONE = 16'd4096;
	localparam int          ID_FIELD_W  = 20;

endpackage

FILE: hdl/lod_frustum_mesh_select.sv
// ----------------------------------------------------------------------------
// lod_frustum_mesh_select
// Per-object distance and frustum culling with full/simple mesh selection.
// ----------------------------------------------------------------------------
// channel   dir  tdata / data                       tuser / index
// s_axis    in   mesh ids, position, size, limits   shader_id, hard_transitions
// m_axis    out  chosen_mesh                        decision
// cfg       in   64-bit register value              register index
//
// Four-stage pipeline: one object per cycle unless the output stalls; each
// object passes stages 1 to 4 in order. Each stage holds while the one after
// it is full and stalled, so bubbles are squeezed out. Reset clears valid bits
// and loads register defaults. Config writes are taken every cycle.
// ----------------------------------------------------------------------------
module lod_frustum_mesh_select
	import lfms_pkg::*;
#(
	parameter int MESH_ID_BITS = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// full_mesh, simple_mesh, pos_x, pos_y, pos_z, object_size, max_distance,
	// simple_distance, zero fill
	input  logic [167:0] s_axis_tdata,
	// shader_id, hard_transitions
	input  logic [8:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// chosen_mesh, zero fill
	output logic [23:0]  m_axis_tdata,
	// decision
	output logic [2:0]   m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	localparam int ID_W = (MESH_ID_BITS < ID_FIELD_W) ? MESH_ID_BITS : ID_FIELD_W;
	localparam logic [ID_FIELD_W:0] ID_ONE = 1;
	localparam logic [ID_FIELD_W-1:0] ID_MASK = ID_FIELD_W'((ID_ONE << ID_W) - ID_ONE);

	logic [62:0] cam_q;
	logic [63:0] row_x_q, row_y_q, row_w_q;
	logic [15:0] fov_q, qual_q;
	logic [7:0]  byp_min_q, sky_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q     <= '0;
			row_x_q   <= '0;
			row_y_q   <= '0;
			row_w_q   <= '0;
			fov_q     <= '0;
			qual_q    <= QUALITY_ONE;
			byp_min_q <= 8'hFF;
			sky_q     <= 8'hFF;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CAMERA_POS:  cam_q     <= cfg_data[62:0];
				REG_CLIP_ROW_X:  row_x_q   <= cfg_data;
				REG_CLIP_ROW_Y:  row_y_q   <= cfg_data;
				REG_CLIP_ROW_W:  row_w_q   <= cfg_data;
				REG_FOV_BIAS:    fov_q     <= cfg_data[15:0];
				REG_LOD_QUALITY: qual_q    <= cfg_data[15:0];
				REG_BYPASS_MIN:  byp_min_q <= cfg_data[7:0];
				REG_SKY_SHADER:  sky_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input unpack
	logic [19:0] in_full, in_simple, in_size, in_maxd, in_simd;
	logic signed [20:0] in_px, in_py, in_pz;
	logic [7:0] in_shader;
	logic       in_hard;
	logic       in_byp;
	logic [15:0] in_q;

	assign in_full   = s_axis_tdata[19:0] & ID_MASK;
	assign in_simple = s_axis_tdata[39:20] & ID_MASK;
	assign in_px     = s_axis_tdata[60:40];
	assign in_py     = s_axis_tdata[81:61];
	assign in_pz     = s_axis_tdata[102:82];
	assign in_size   = s_axis_tdata[122:103];
	assign in_maxd   = s_axis_tdata[142:123];
	assign in_simd   = s_axis_tdata[162:143];
	assign in_shader = s_axis_tuser[7:0];
	assign in_hard   = s_axis_tuser[8];
	assign in_byp    = (in_shader >= byp_min_q) || (in_shader == sky_q);
	assign in_q      = in_hard ? QUALITY_ONE : qual_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || m_axis_tready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: differences, clip products, scaled limits, mesh fix-up
	logic        byp_s1, hard_s1;
	logic [19:0] full_s1, simple_s1;
	logic signed [21:0] dx_s1, dy_s1, dz_s1;
	logic signed [36:0] pxx_s1, pxy_s1, pxz_s1, pyx_s1, pyy_s1, pyz_s1;
	logic signed [36:0] pwx_s1, pwy_s1, pwz_s1;
	logic signed [15:0] offx_s1, offy_s1, offw_s1;
	logic [35:0] maxq_s1, simq_s1, k_s1;
	logic [39:0] size2_s1;

	logic [19:0] fx_full, fx_simple;
	always_comb begin
		fx_full   = (in_full == '0) ? in_simple : in_full;
		fx_simple = (in_simple == '0) ? fx_full : in_simple;
	end

	// bypass keeps the full id as given, even when empty
	always_ff @(posedge clk) begin
		if (en1) begin
			byp_s1    <= in_byp;
			hard_s1   <= in_hard;
			full_s1   <= in_byp ? in_full : fx_full;
			simple_s1 <= fx_simple;
			dx_s1 <= 22'(in_px) - 22'($signed(cam_q[20:0]));
			dy_s1 <= 22'(in_py) - 22'($signed(cam_q[41:21]));
			dz_s1 <= 22'(in_pz) - 22'($signed(cam_q[62:42]));
			pxx_s1 <= $signed(row_x_q[15:0])  * in_px;
			pxy_s1 <= $signed(row_x_q[31:16]) * in_py;
			pxz_s1 <= $signed(row_x_q[47:32]) * in_pz;
			pyx_s1 <= $signed(row_y_q[15:0])  * in_px;
			pyy_s1 <= $signed(row_y_q[31:16]) * in_py;
			pyz_s1 <= $signed(row_y_q[47:32]) * in_pz;
			pwx_s1 <= $signed(row_w_q[15:0])  * in_px;
			pwy_s1 <= $signed(row_w_q[31:16]) * in_py;
			pwz_s1 <= $signed(row_w_q[47:32]) * in_pz;
			offx_s1 <= $signed(row_x_q[63:48]);
			offy_s1 <= $signed(row_y_q[63:48]);
			offw_s1 <= $signed(row_w_q[63:48]);
			maxq_s1  <= 36'(in_maxd) * 36'(in_q);
			simq_s1  <= 36'(in_simd) * 36'(in_q);
			k_s1     <= 36'(in_size) * 36'(fov_q);
			size2_s1 <= 40'(in_size) * 40'(in_size);
		end
	end

	// stage 2: squares and clip sums
	logic        byp_s2, hard_s2;
	logic [19:0] full_s2, simple_s2;
	logic [42:0] dx2_s2, dy2_s2, dz2_s2;
	logic signed [39:0] cx_s2, cy_s2, cw_s2;
	logic [47:0] max2_s2, sim2_s2;
	logic [35:0] k_s2;
	logic [39:0] size2_s2;

	logic [23:0] maxs, sims;
	assign maxs = maxq_s1[35:12];
	assign sims = simq_s1[35:12];

	always_ff @(posedge clk) begin
		if (en2) begin
			byp_s2    <= byp_s1;
			hard_s2   <= hard_s1;
			full_s2   <= full_s1;
			simple_s2 <= simple_s1;
			dx2_s2 <= 43'(44'(dx_s1 * dx_s1));
			dy2_s2 <= 43'(44'(dy_s1 * dy_s1));
			dz2_s2 <= 43'(44'(dz_s1 * dz_s1));
			cx_s2 <= 40'(pxx_s1) + 40'(pxy_s1) + 40'(pxz_s1) + (40'(offx_s1) <<< 12);
			cy_s2 <= 40'(pyx_s1) + 40'(pyy_s1) + 40'(pyz_s1) + (40'(offy_s1) <<< 12);
			cw_s2 <= 40'(pwx_s1) + 40'(pwy_s1) + 40'(pwz_s1) + (40'(offw_s1) <<< 12);
			max2_s2  <= 48'(maxs) * 48'(maxs);
			sim2_s2  <= 48'(sims) * 48'(sims);
			k_s2     <= k_s1;
			size2_s2 <= size2_s1;
		end
	end

	// stage 3: distance sum, bounds, magnitudes
	logic        byp_s3, hard_s3, wz_s3;
	logic [19:0] full_s3, simple_s3;
	logic [43:0] dist2_s3;
	logic signed [40:0] ax_s3, ay_s3, bound_s3;
	logic [47:0] max2_s3, sim2_s3;
	logic [39:0] size2_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			byp_s3    <= byp_s2;
			hard_s3   <= hard_s2;
			full_s3   <= full_s2;
			simple_s3 <= simple_s2;
			dist2_s3  <= 44'(dx2_s2) + 44'(dy2_s2) + 44'(dz2_s2);
			ax_s3 <= cx_s2[39] ? -41'(cx_s2) : 41'(cx_s2);
			ay_s3 <= cy_s2[39] ? -41'(cy_s2) : 41'(cy_s2);
			bound_s3 <= (cw_s2 > 0) ? 41'(cw_s2) + $signed({5'd0, k_s2})
			                        : -41'(cw_s2) - $signed({5'd0, k_s2});
			wz_s3    <= (cw_s2 == '0);
			max2_s3  <= max2_s2;
			sim2_s3  <= sim2_s2;
			size2_s3 <= size2_s2;
		end
	end

	// stage 4: decision
	dec_t        dec_d;
	logic [19:0] mesh_d;
	always_comb begin
		mesh_d = '0;
		if (byp_s3) begin
			dec_d  = DEC_BYPASS;
			mesh_d = full_s3;
		end else if (full_s3 == '0) begin
			dec_d = DEC_NO_MESH;
		end else if (!hard_s3 && (dist2_s3 < 44'(size2_s3))) begin
			dec_d  = DEC_NEAR;
			mesh_d = full_s3;
		end else if (48'(dist2_s3) > max2_s3) begin
			dec_d = DEC_TOO_FAR;
		end else if (wz_s3 || (ax_s3 > bound_s3) || (ay_s3 > bound_s3)) begin
			dec_d = DEC_OFF_SCREEN;
		end else if (48'(dist2_s3) > sim2_s3) begin
			dec_d  = DEC_SIMPLE;
			mesh_d = simple_s3;
		end else begin
			dec_d  = DEC_FULL;
			mesh_d = full_s3;
		end
	end

	dec_t        dec_s4;
	logic [19:0] mesh_s4;
	always_ff @(posedge clk) begin
		if (en4) begin
			dec_s4  <= dec_d;
			mesh_s4 <= mesh_d;
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = {4'd0, mesh_s4};
	assign m_axis_tuser  = dec_s4;

	a_cull_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == DEC_TOO_FAR || m_axis_tuser == DEC_OFF_SCREEN
		|| m_axis_tuser == DEC_NO_MESH) |-> m_axis_tdata == '0)
		else $error("culled result carries a mesh id");
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_axis_tready)
		else $error("input stalled with empty first stage");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !v_s4 |=> m_axis_tvalid)
		else $error("result lost between last stages");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Frustum cull and mesh LOD selector: directed table of corner objects, then
// randomised objects under several register settings with random idling on
// both streams. Every result is checked field by field against a table entry or a predictor.
// ----------------------------------------------------------------------------
module tb_top;
	import lfms_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct {
		logic [7:0]  shader;
		logic [19:0] full_id;
		logic [19:0] simple_id;
		logic [20:0] px;
		logic [20:0] py;
		logic [20:0] pz;
		logic [19:0] size;
		logic [19:0] max_d;
		logic [19:0] sim_d;
		logic        hard;
	} object_t;

	typedef struct {
		logic [19:0] mesh;
		dec_t        dec;
	} pick_t;

	typedef struct {
		object_t obj;
		logic    known;
		pick_t   pick;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [167:0] s_axis_tdata;
	logic [8:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [23:0]  m_axis_tdata;
	logic [2:0]   m_axis_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [7:0]   cfg_index;
	logic [63:0]  cfg_data;

	logic [62:0] cam_pos;
	logic [63:0] row_x, row_y, row_w;
	logic [15:0] fov_gain, quality;
	logic [7:0]  bypass_min, sky_id;

	pick_t pending_picks[$];
	int    errors;
	int    cycles;
	bit    calm;
	bit    hold_off;
	int    hold_left;

	lod_frustum_mesh_select u_dut (.*);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic longint clip_of(logic [63:0] r, object_t o);
		longint gx, gy, gz, off;
		gx = longint'($signed(r[15:0]));
		gy = longint'($signed(r[31:16]));
		gz = longint'($signed(r[47:32]));
		off = longint'($signed(r[63:48]));
		return gx * longint'($signed(o.px)) + gy * longint'($signed(o.py))
			+ gz * longint'($signed(o.pz)) + off * 4096;
	endfunction

	function automatic pick_t choose_mesh(object_t o);
		pick_t p;
		logic [19:0] fm, sm;
		longint dx, dy, dz, cx, cy, cw, k, ax, ay, bound;
		longint unsigned dist2, q, maxs, sims, sz;
		fm = o.full_id;
		sm = o.simple_id;
		p.mesh = '0;
		if (o.shader >= bypass_min || o.shader == sky_id) begin
			p.mesh = fm;
			p.dec = DEC_BYPASS;
			return p;
		end
		if (fm == 0) fm = sm;
		if (sm == 0) sm = fm;
		if (fm == 0) begin
			p.dec = DEC_NO_MESH;
			return p;
		end
		dx = longint'($signed(o.px)) - longint'($signed(cam_pos[20:0]));
		dy = longint'($signed(o.py)) - longint'($signed(cam_pos[41:21]));
		dz = longint'($signed(o.pz)) - longint'($signed(cam_pos[62:42]));
		dist2 = dx * dx + dy * dy + dz * dz;
		q = o.hard ? 4096 : quality;
		maxs = (longint'(o.max_d) * q) >> 12;
		sims = (longint'(o.sim_d) * q) >> 12;
		sz = o.size;
		if (!o.hard && dist2 < sz * sz) begin
			p.mesh = fm;
			p.dec = DEC_NEAR;
		end else if (dist2 > maxs * maxs) begin
			p.dec = DEC_TOO_FAR;
		end else begin
			cx = clip_of(row_x, o);
			cy = clip_of(row_y, o);
			cw = clip_of(row_w, o);
			k = longint'(sz * fov_gain);
			ax = cx < 0 ? -cx : cx;
			ay = cy < 0 ? -cy : cy;
			bound = cw > 0 ? cw + k : -cw - k;
			if (cw == 0 || ax > bound || ay > bound) begin
				p.dec = DEC_OFF_SCREEN;
			end else if (dist2 > sims * sims) begin
				p.mesh = sm;
				p.dec = DEC_SIMPLE;
			end else begin
				p.mesh = fm;
				p.dec = DEC_FULL;
			end
		end
		return p;
	endfunction

	// receiver: random stalls, calm stretches, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
		end else if (hold_off && hold_left == 0) begin
			hold_left <= 300;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 1) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			hold_left <= hold_off ? 1 : 0;
			m_axis_tready <= (hold_left == 1) ? 1'b1 : (calm || $urandom_range(99) >= 22);
		end
	end

	always @(posedge clk) begin
		pick_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_picks.size() == 0) begin
				$error("result with nothing pending: mesh %0d", m_axis_tdata[19:0]);
				errors++;
			end else begin
				e = pending_picks.pop_front();
				if (m_axis_tdata[19:0] !== e.mesh) begin
					$error("chosen_mesh expected %0d got %0d", e.mesh, m_axis_tdata[19:0]);
					errors++;
				end
				if (m_axis_tdata[23:20] !== 4'd0) begin
					$error("tdata fill expected 0 got %0h", m_axis_tdata[23:20]);
					errors++;
				end
				if (m_axis_tuser !== e.dec) begin
					$error("decision expected %0d got %0d", e.dec, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [7:0] idx, logic [63:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_CAMERA_POS: cam_pos = val[62:0];
			REG_CLIP_ROW_X: row_x = val;
			REG_CLIP_ROW_Y: row_y = val;
			REG_CLIP_ROW_W: row_w = val;
			REG_FOV_BIAS: fov_gain = val[15:0];
			REG_LOD_QUALITY: quality = val[15:0];
			REG_BYPASS_MIN: bypass_min = val[7:0];
			REG_SKY_SHADER: sky_id = val[7:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_picks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// drives one object; the caller lowers tvalid when the stream ends
	task automatic send_object(object_t o, logic known, pick_t want);
		while (!calm && $urandom_range(99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tdata <= {8'd0, o.sim_d, o.max_d, o.size, o.pz, o.py, o.px,
			o.simple_id, o.full_id};
		s_axis_tuser <= {o.hard, o.shader};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		pending_picks.push_back(known ? want : choose_mesh(o));
	endtask

	function automatic logic [20:0] rand_coord(int span);
		if ($urandom_range(9) == 0) return 21'($urandom);
		return 21'($signed($urandom_range(2 * span) - span));
	endfunction

	function automatic object_t rand_object();
		object_t o;
		o.shader = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(40));
		o.full_id = ($urandom_range(9) == 0) ? 20'd0 : 20'($urandom);
		o.simple_id = ($urandom_range(9) == 0) ? 20'd0 : 20'($urandom);
		o.px = rand_coord(4000);
		o.py = rand_coord(4000);
		o.pz = rand_coord(4000);
		o.size = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(800));
		o.max_d = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(12000));
		o.sim_d = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(6000));
		o.hard = 1'($urandom);
		return o;
	endfunction

	task automatic random_phase(int n);
		repeat (n) send_object(rand_object(), 1'b0, '{mesh: '0, dec: DEC_BYPASS});
		s_axis_tvalid <= 1'b0;
	endtask

	initial begin
		row_t dir[$];
		object_t o;
		pick_t none;
		none = '{mesh: '0, dec: DEC_BYPASS};
		errors = 0;
		cycles = 0;
		calm = 1'b0;
		hold_off = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cam_pos = '0;
		row_x = '0;
		row_y = '0;
		row_w = '0;
		fov_gain = '0;
		quality = QUALITY_ONE;
		bypass_min = 8'd255;
		sky_id = 8'd255;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: shader 255 bypasses, everything else has w = 0
		o = '{shader: 8'd255, full_id: 20'hFFFFF, simple_id: 20'd1, px: 21'h100000,
			py: 21'h0FFFFF, pz: 21'd0, size: 20'd0, max_d: 20'hFFFFF, sim_d: 20'd0,
			hard: 1'b1};
		dir.push_back('{o, 1'b1, '{20'hFFFFF, DEC_BYPASS}});
		o.full_id = 20'd0;
		dir.push_back('{o, 1'b1, '{20'd0, DEC_BYPASS}});
		o.shader = 8'd0;
		o.simple_id = 20'd0;
		dir.push_back('{o, 1'b1, '{20'd0, DEC_NO_MESH}});
		o.simple_id = 20'd9;
		o.px = 21'd0;
		o.py = 21'd0;
		o.size = 20'd5;
		o.hard = 1'b0;
		dir.push_back('{o, 1'b1, '{20'd9, DEC_NEAR}});
		o.px = 21'd100;
		o.max_d = 20'd10;
		dir.push_back('{o, 1'b1, '{20'd0, DEC_TOO_FAR}});
		o.max_d = 20'hFFFFF;
		dir.push_back('{o, 1'b1, '{20'd0, DEC_OFF_SCREEN}});
		foreach (dir[i]) send_object(dir[i].obj, dir[i].known, dir[i].pick);
		s_axis_tvalid <= 1'b0;
		drain();

		// simple frustum: x,y pass, w = z + 256
		write_reg(REG_CLIP_ROW_X, {16'd0, 16'd0, 16'd0, 16'd4096});
		write_reg(REG_CLIP_ROW_Y, {16'd0, 16'd0, 16'd4096, 16'd0});
		write_reg(REG_CLIP_ROW_W, {16'd256, 16'd4096, 16'd0, 16'd0});
		write_reg(REG_FOV_BIAS, 64'd4096);
		write_reg(REG_BYPASS_MIN, 64'd200);
		write_reg(REG_SKY_SHADER, 64'd100);
		write_reg(8'd9, 64'hFFFF);
		dir.delete();
		o = '{shader: 8'd100, full_id: 20'd3, simple_id: 20'd4, px: 21'd10,
			py: 21'd10, pz: 21'd500, size: 20'd0, max_d: 20'hFFFFF, sim_d: 20'd100,
			hard: 1'b0};
		dir.push_back('{o, 1'b1, '{20'd3, DEC_BYPASS}});
		o.shader = 8'd199;
		dir.push_back('{o, 1'b0, none});
		o.shader = 8'd1;
		dir.push_back('{o, 1'b0, none});
		o.sim_d = 20'hFFFFF;
		dir.push_back('{o, 1'b0, none});
		o.full_id = 20'd0;
		dir.push_back('{o, 1'b0, none});
		o.px = 21'h0FFFFF;
		o.size = 20'hFFFFF;
		o.hard = 1'b1;
		dir.push_back('{o, 1'b0, none});
		o.pz = 21'h100000;
		dir.push_back('{o, 1'b0, none});
		foreach (dir[i]) send_object(dir[i].obj, dir[i].known, dir[i].pick);
		s_axis_tvalid <= 1'b0;
		drain();

		// long receiver hold-off with the sender still pushing
		calm = 1'b1;
		hold_off = 1'b1;
		random_phase(20);
		hold_off = 1'b0;
		random_phase(60);
		calm = 1'b0;
		drain();

		write_reg(REG_LOD_QUALITY, 64'd0);
		write_reg(REG_CAMERA_POS, {21'h100000, 21'h0FFFFF, 21'd0});
		random_phase(50);
		drain();

		write_reg(REG_LOD_QUALITY, 64'hFFFF);
		write_reg(REG_FOV_BIAS, 64'hFFFF);
		write_reg(REG_CAMERA_POS, 63'd0);
		write_reg(REG_BYPASS_MIN, 64'd0);
		random_phase(20);
		drain();

		write_reg(REG_BYPASS_MIN, 64'd255);
		write_reg(REG_SKY_SHADER, 64'd0);
		write_reg(REG_LOD_QUALITY, 64'd2048);
		write_reg(REG_FOV_BIAS, 64'd800);
		write_reg(REG_CLIP_ROW_X, 64'hFFFF_8000_7FFF_1234);
		write_reg(REG_CLIP_ROW_Y, 64'h8000_0400_F000_0800);
		write_reg(REG_CLIP_ROW_W, 64'hFFFF_FFFF_FFFF_FFFF);
		random_phase(60);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_CAMERA_POS, {$urandom, $urandom});
			write_reg(REG_CLIP_ROW_X, {16'($urandom), 16'($urandom_range(1200)),
				16'($urandom_range(1200)), 16'($urandom_range(8192))});
			write_reg(REG_CLIP_ROW_Y, {16'($urandom), 16'($urandom_range(1200)),
				16'($urandom_range(8192)), 16'($urandom_range(1200))});
			write_reg(REG_CLIP_ROW_W, {16'($urandom), 16'($urandom_range(8192)),
				16'($urandom), 16'($urandom)});
			write_reg(REG_FOV_BIAS, 64'($urandom));
			write_reg(REG_LOD_QUALITY, 64'($urandom));
			write_reg(REG_BYPASS_MIN, 64'($urandom_range(20, 255)));
			write_reg(REG_SKY_SHADER, 64'($urandom));
			random_phase(50);
			drain();
		end

		drain();
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/lfms_pkg.sv
hdl/lod_frustum_mesh_select.sv
tb/tb_top.sv
